// ===== rtl/core/brown_lens_distortion_correction_defines.svh =====
// Assertion macros for the lens correction core.
`ifndef BROWN_LENS_DISTORTION_CORRECTION_DEFINES_SVH
`define BROWN_LENS_DISTORTION_CORRECTION_DEFINES_SVH

`ifndef SYNTHESIS

// ante holds in a cycle, then cons holds in the same cycle
`define BLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blc: same-cycle check failed");

// ante holds in a cycle, then cons holds in the next cycle
`define BLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blc: next-cycle check failed");

`else

`define BLC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/blc_pkg.sv =====
package blc_pkg;

  // pipeline depth, one register stage per entry
  localparam int unsigned NumStages = 13;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // normalized offset, Q16, worst case at the smallest normalization shift
  localparam int unsigned CoordW = 23;
  typedef logic signed [CoordW-1:0] coord_t;

  // radial factor before and after saturation, Q29
  localparam int unsigned RadSumW = 50;
  localparam int unsigned RadW    = 42;
  localparam logic signed [RadSumW-1:0] RadOne = 50'sd536870912;
  localparam logic signed [RadSumW-1:0] RadLim = 50'sd1099511627776;

  // Q16 saturation for r^4 and r^6
  localparam logic [30:0] Q16Lim = '1;

  // register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_K1       = 3'd2,
    REG_K2       = 3'd3,
    REG_K3       = 3'd4,
    REG_P1       = 3'd5,
    REG_P2       = 3'd6
  } cfg_reg_e;

  // register reset values
  localparam logic [15:0]        CenterXRst = 16'd5012;
  localparam logic [15:0]        CenterYRst = 16'd3773;
  localparam logic signed [31:0] K1Rst      = 32'sd118;
  localparam logic signed [31:0] K2Rst      = 32'sd0;
  localparam logic signed [31:0] K3Rst      = 32'sd0;
  localparam logic signed [31:0] P1Rst      = -32'sd1687;
  localparam logic signed [31:0] P2Rst      = 32'sd2684;

endpackage

// ===== rtl/core/brown_lens_distortion_correction.sv =====
// Brown-Conrady lens correction, one coordinate pair per request.
// Pipeline: 13 register stages; an accepted request enters stage 0 and leaves through
// stage 12, whose registers drive the outputs.
// Throughput: one request per cycle; a stalled output only backs up full stages,
// empty stages keep absorbing new requests.
// Reset: pipeline valid bits clear; coefficient and center registers return to defaults.
`include "brown_lens_distortion_correction_defines.svh"

module brown_lens_distortion_correction #(
  parameter int unsigned IMAGE_WIDTH  = 640,
  parameter int unsigned IMAGE_HEIGHT = 480,
  parameter int unsigned NORM_SHIFT   = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [blc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [blc_pkg::CfgDataW-1:0]  cfg_data_i,
  // raw pixel requests
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [11:0]                   pixel_x_i,
  input  logic [11:0]                   pixel_y_i,
  // corrected results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [13:0]            ideal_x_o,
  output logic signed [13:0]            ideal_y_o,
  output logic                          in_bounds_o
);

  localparam int unsigned NSt      = blc_pkg::NumStages;
  localparam int unsigned PreShift = 12 - NORM_SHIFT;
  localparam logic signed [13:0] WidthLim  = 14'(IMAGE_WIDTH);
  localparam logic signed [13:0] HeightLim = 14'(IMAGE_HEIGHT);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0]        center_x_q, center_y_q;
  logic signed [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= blc_pkg::CenterXRst;
      center_y_q <= blc_pkg::CenterYRst;
      k1_q       <= blc_pkg::K1Rst;
      k2_q       <= blc_pkg::K2Rst;
      k3_q       <= blc_pkg::K3Rst;
      p1_q       <= blc_pkg::P1Rst;
      p2_q       <= blc_pkg::P2Rst;
    end else if (cfg_valid_i) begin
      unique case (blc_pkg::cfg_reg_e'(cfg_index_i))
        blc_pkg::REG_CENTER_X: center_x_q <= cfg_data_i[15:0];
        blc_pkg::REG_CENTER_Y: center_y_q <= cfg_data_i[15:0];
        blc_pkg::REG_K1:       k1_q       <= $signed(cfg_data_i);
        blc_pkg::REG_K2:       k2_q       <= $signed(cfg_data_i);
        blc_pkg::REG_K3:       k3_q       <= $signed(cfg_data_i);
        blc_pkg::REG_P1:       p1_q       <= $signed(cfg_data_i);
        blc_pkg::REG_P2:       p2_q       <= $signed(cfg_data_i);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage moves unless it and every stage after it
  // are full and the output is stalled (bubbles get squeezed out).
  // ---------------------------------------------------------------------------
  logic [NSt-1:0] vld_q;
  logic [NSt-1:0] adv;

  always_comb begin
    logic [NSt-1:0] low_mask;
    low_mask = '0;
    for (int k = 0; k < NSt; k++) begin
      low_mask = (NSt'(1) << k) - NSt'(1);
      adv[k]   = !out_stall_i || !(&(vld_q | low_mask));
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NSt; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: offset from principal point, normalized to Q16
  // ---------------------------------------------------------------------------
  logic signed [17:0] dx, dy;
  blc_pkg::coord_t    s0_x_d, s0_y_d, s0_x_q, s0_y_q;

  assign dx     = $signed({2'b00, pixel_x_i, 4'b0000}) - $signed({2'b00, center_x_q});
  assign dy     = $signed({2'b00, pixel_y_i, 4'b0000}) - $signed({2'b00, center_y_q});
  assign s0_x_d = blc_pkg::coord_t'(dx) <<< PreShift;
  assign s0_y_d = blc_pkg::coord_t'(dy) <<< PreShift;

  // Stage 1: squares and cross product
  logic signed [45:0] s1_xx_d, s1_yy_d, s1_xy_d, s1_xx_q, s1_yy_q, s1_xy_q;
  blc_pkg::coord_t    s1_x_q, s1_y_q;

  assign s1_xx_d = s0_x_q * s0_x_q;
  assign s1_yy_d = s0_y_q * s0_y_q;
  assign s1_xy_d = s0_x_q * s0_y_q;

  // Stage 2: r^2, x^2, y^2, xy in Q16
  logic signed [45:0] sq_sum;
  logic [29:0]        s2_r2_d, s2_r2_q;
  logic [28:0]        s2_x2_d, s2_y2_d, s2_x2_q, s2_y2_q;
  logic signed [29:0] s2_xy_d, s2_xy_q;
  blc_pkg::coord_t    s2_x_q, s2_y_q;

  assign sq_sum  = s1_xx_q + s1_yy_q;
  assign s2_r2_d = 30'(sq_sum >>> 16);
  assign s2_x2_d = 29'(s1_xx_q >>> 16);
  assign s2_y2_d = 29'(s1_yy_q >>> 16);
  assign s2_xy_d = 30'(s1_xy_q >>> 16);

  // Stage 3: r^4 product, k1 term, tangential products
  logic [29:0]        tx_sum, ty_sum;
  logic [59:0]        s3_r2sq_d, s3_r2sq_q;
  logic signed [62:0] s3_k1r2_d, s3_k1r2_q;
  logic signed [62:0] s3_ptx_d, s3_pty_d, s3_ptx_q, s3_pty_q;
  logic signed [61:0] s3_pxyx_d, s3_pxyy_d, s3_pxyx_q, s3_pxyy_q;
  logic [29:0]        s3_r2_q;
  blc_pkg::coord_t    s3_x_q, s3_y_q;

  assign tx_sum    = s2_r2_q + {s2_x2_q, 1'b0};
  assign ty_sum    = s2_r2_q + {s2_y2_q, 1'b0};
  assign s3_r2sq_d = s2_r2_q * s2_r2_q;
  assign s3_k1r2_d = k1_q * $signed({1'b0, s2_r2_q});
  assign s3_ptx_d  = p1_q * $signed({1'b0, tx_sum});
  assign s3_pty_d  = p2_q * $signed({1'b0, ty_sum});
  assign s3_pxyx_d = p2_q * s2_xy_q;
  assign s3_pxyy_d = p1_q * s2_xy_q;

  // Stage 4: saturate r^4, scale k1 and tangential terms
  logic [43:0]        r4_full;
  logic [30:0]        s4_r4_d, s4_r4_q;
  logic signed [46:0] s4_k1t_d, s4_k1t_q;
  logic signed [33:0] s4_tx1_d, s4_tx2_d, s4_ty1_d, s4_ty2_d;
  logic signed [33:0] s4_tx1_q, s4_tx2_q, s4_ty1_q, s4_ty2_q;
  logic [29:0]        s4_r2_q;
  blc_pkg::coord_t    s4_x_q, s4_y_q;

  assign r4_full  = 44'(s3_r2sq_q >> 16);
  assign s4_r4_d  = (|r4_full[43:31]) ? blc_pkg::Q16Lim : r4_full[30:0];
  assign s4_k1t_d = 47'(s3_k1r2_q >>> 16);
  assign s4_tx1_d = 34'(s3_ptx_q >>> 29);
  assign s4_ty1_d = 34'(s3_pty_q >>> 29);
  // 2*p*xy >> 29 folds into one shift by 28
  assign s4_tx2_d = 34'(s3_pxyx_q >>> 28);
  assign s4_ty2_d = 34'(s3_pxyy_q >>> 28);

  // Stage 5: r^6 product, k2 term
  logic [60:0]        s5_r4r2_d, s5_r4r2_q;
  logic signed [63:0] s5_k2r4_d, s5_k2r4_q;
  logic signed [46:0] s5_k1t_q;
  logic signed [33:0] s5_tx1_q, s5_tx2_q, s5_ty1_q, s5_ty2_q;
  blc_pkg::coord_t    s5_x_q, s5_y_q;

  assign s5_r4r2_d = s4_r4_q * s4_r2_q;
  assign s5_k2r4_d = k2_q * $signed({1'b0, s4_r4_q});

  // Stage 6: saturate r^6, scale k2 term
  logic [44:0]        r6_full;
  logic [30:0]        s6_r6_d, s6_r6_q;
  logic signed [47:0] s6_k2t_d, s6_k2t_q;
  logic signed [46:0] s6_k1t_q;
  logic signed [33:0] s6_tx1_q, s6_tx2_q, s6_ty1_q, s6_ty2_q;
  blc_pkg::coord_t    s6_x_q, s6_y_q;

  assign r6_full  = 45'(s5_r4r2_q >> 16);
  assign s6_r6_d  = (|r6_full[44:31]) ? blc_pkg::Q16Lim : r6_full[30:0];
  assign s6_k2t_d = 48'(s5_k2r4_q >>> 16);

  // Stage 7: k3 term, partial radial sum
  logic signed [63:0]                    s7_k3r6_d, s7_k3r6_q;
  logic signed [blc_pkg::RadSumW-1:0]    s7_ks_d, s7_ks_q;
  logic signed [33:0] s7_tx1_q, s7_tx2_q, s7_ty1_q, s7_ty2_q;
  blc_pkg::coord_t    s7_x_q, s7_y_q;

  assign s7_k3r6_d = k3_q * $signed({1'b0, s6_r6_q});
  assign s7_ks_d   = blc_pkg::RadSumW'(s6_k1t_q) + blc_pkg::RadSumW'(s6_k2t_q);

  // Stage 8: radial factor with saturation
  logic signed [blc_pkg::RadSumW-1:0] rad_sum;
  logic signed [blc_pkg::RadW-1:0]    s8_rad_d, s8_rad_q;
  logic signed [33:0] s8_tx1_q, s8_tx2_q, s8_ty1_q, s8_ty2_q;
  blc_pkg::coord_t    s8_x_q, s8_y_q;

  assign rad_sum = blc_pkg::RadOne + s7_ks_q + blc_pkg::RadSumW'(s7_k3r6_q >>> 16);

  always_comb begin
    priority if (rad_sum > blc_pkg::RadLim) begin
      s8_rad_d = blc_pkg::RadW'(blc_pkg::RadLim);
    end else if (rad_sum < -blc_pkg::RadLim) begin
      s8_rad_d = blc_pkg::RadW'(-blc_pkg::RadLim);
    end else begin
      s8_rad_d = blc_pkg::RadW'(rad_sum);
    end
  end

  // Stage 9: offset times radial factor, split into two partial products
  logic signed [44:0] s9_xlo_d, s9_ylo_d, s9_xlo_q, s9_ylo_q;
  logic signed [43:0] s9_xhi_d, s9_yhi_d, s9_xhi_q, s9_yhi_q;
  logic signed [33:0] s9_tx1_q, s9_tx2_q, s9_ty1_q, s9_ty2_q;

  assign s9_xlo_d = s8_x_q * $signed({1'b0, s8_rad_q[20:0]});
  assign s9_ylo_d = s8_y_q * $signed({1'b0, s8_rad_q[20:0]});
  assign s9_xhi_d = s8_x_q * $signed(s8_rad_q[41:21]);
  assign s9_yhi_d = s8_y_q * $signed(s8_rad_q[41:21]);

  // Stage 10: recombine partial products, back to Q16
  logic signed [65:0] x_full, y_full;
  logic signed [35:0] s10_xr_d, s10_yr_d, s10_xr_q, s10_yr_q;
  logic signed [33:0] s10_tx1_q, s10_tx2_q, s10_ty1_q, s10_ty2_q;

  assign x_full   = (66'(s9_xhi_q) <<< 21) + 66'(s9_xlo_q);
  assign y_full   = (66'(s9_yhi_q) <<< 21) + 66'(s9_ylo_q);
  assign s10_xr_d = 36'(x_full >>> 29);
  assign s10_yr_d = 36'(y_full >>> 29);

  // Stage 11: corrected normalized offset
  logic signed [35:0] s11_ox_d, s11_oy_d, s11_ox_q, s11_oy_q;

  assign s11_ox_d = s10_xr_q + 36'(s10_tx1_q) + 36'(s10_tx2_q);
  assign s11_oy_d = s10_yr_q + 36'(s10_ty1_q) + 36'(s10_ty2_q);

  // Stage 12: back to pixels, truncate toward zero, saturate, bounds check
  function automatic logic signed [13:0] to_pixel(input logic [15:0]        center,
                                                  input logic signed [35:0] corr);
    logic signed [49:0] t;
    logic signed [49:0] t_adj;
    logic signed [33:0] q;
    logic signed [13:0] r;
    t     = $signed({22'b0, center, 12'b0}) + (50'(corr) <<< NORM_SHIFT);
    t_adj = t[49] ? (t + 50'sd65535) : t;
    q     = 34'(t_adj >>> 16);
    priority if (q > 34'sd8191) begin
      r = 14'sd8191;
    end else if (q < -34'sd8192) begin
      r = -14'sd8192;
    end else begin
      r = 14'(q);
    end
    return r;
  endfunction

  logic signed [13:0] s12_ix_d, s12_iy_d, s12_ix_q, s12_iy_q;
  logic               s12_inb_d, s12_inb_q;

  assign s12_ix_d  = to_pixel(center_x_q, s11_ox_q);
  assign s12_iy_d  = to_pixel(center_y_q, s11_oy_q);
  assign s12_inb_d = !s12_ix_d[13] && (s12_ix_d < WidthLim) &&
                     !s12_iy_d[13] && (s12_iy_d < HeightLim);

  // ---------------------------------------------------------------------------
  // Payload registers, each stage loads when it advances
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_x_q <= s0_x_d;
      s0_y_q <= s0_y_d;
    end
    if (adv[1]) begin
      s1_xx_q <= s1_xx_d;
      s1_yy_q <= s1_yy_d;
      s1_xy_q <= s1_xy_d;
      s1_x_q  <= s0_x_q;
      s1_y_q  <= s0_y_q;
    end
    if (adv[2]) begin
      s2_r2_q <= s2_r2_d;
      s2_x2_q <= s2_x2_d;
      s2_y2_q <= s2_y2_d;
      s2_xy_q <= s2_xy_d;
      s2_x_q  <= s1_x_q;
      s2_y_q  <= s1_y_q;
    end
    if (adv[3]) begin
      s3_r2sq_q <= s3_r2sq_d;
      s3_k1r2_q <= s3_k1r2_d;
      s3_ptx_q  <= s3_ptx_d;
      s3_pty_q  <= s3_pty_d;
      s3_pxyx_q <= s3_pxyx_d;
      s3_pxyy_q <= s3_pxyy_d;
      s3_r2_q   <= s2_r2_q;
      s3_x_q    <= s2_x_q;
      s3_y_q    <= s2_y_q;
    end
    if (adv[4]) begin
      s4_r4_q  <= s4_r4_d;
      s4_k1t_q <= s4_k1t_d;
      s4_tx1_q <= s4_tx1_d;
      s4_tx2_q <= s4_tx2_d;
      s4_ty1_q <= s4_ty1_d;
      s4_ty2_q <= s4_ty2_d;
      s4_r2_q  <= s3_r2_q;
      s4_x_q   <= s3_x_q;
      s4_y_q   <= s3_y_q;
    end
    if (adv[5]) begin
      s5_r4r2_q <= s5_r4r2_d;
      s5_k2r4_q <= s5_k2r4_d;
      s5_k1t_q  <= s4_k1t_q;
      s5_tx1_q  <= s4_tx1_q;
      s5_tx2_q  <= s4_tx2_q;
      s5_ty1_q  <= s4_ty1_q;
      s5_ty2_q  <= s4_ty2_q;
      s5_x_q    <= s4_x_q;
      s5_y_q    <= s4_y_q;
    end
    if (adv[6]) begin
      s6_r6_q  <= s6_r6_d;
      s6_k2t_q <= s6_k2t_d;
      s6_k1t_q <= s5_k1t_q;
      s6_tx1_q <= s5_tx1_q;
      s6_tx2_q <= s5_tx2_q;
      s6_ty1_q <= s5_ty1_q;
      s6_ty2_q <= s5_ty2_q;
      s6_x_q   <= s5_x_q;
      s6_y_q   <= s5_y_q;
    end
    if (adv[7]) begin
      s7_k3r6_q <= s7_k3r6_d;
      s7_ks_q   <= s7_ks_d;
      s7_tx1_q  <= s6_tx1_q;
      s7_tx2_q  <= s6_tx2_q;
      s7_ty1_q  <= s6_ty1_q;
      s7_ty2_q  <= s6_ty2_q;
      s7_x_q    <= s6_x_q;
      s7_y_q    <= s6_y_q;
    end
    if (adv[8]) begin
      s8_rad_q <= s8_rad_d;
      s8_tx1_q <= s7_tx1_q;
      s8_tx2_q <= s7_tx2_q;
      s8_ty1_q <= s7_ty1_q;
      s8_ty2_q <= s7_ty2_q;
      s8_x_q   <= s7_x_q;
      s8_y_q   <= s7_y_q;
    end
    if (adv[9]) begin
      s9_xlo_q <= s9_xlo_d;
      s9_ylo_q <= s9_ylo_d;
      s9_xhi_q <= s9_xhi_d;
      s9_yhi_q <= s9_yhi_d;
      s9_tx1_q <= s8_tx1_q;
      s9_tx2_q <= s8_tx2_q;
      s9_ty1_q <= s8_ty1_q;
      s9_ty2_q <= s8_ty2_q;
    end
    if (adv[10]) begin
      s10_xr_q  <= s10_xr_d;
      s10_yr_q  <= s10_yr_d;
      s10_tx1_q <= s9_tx1_q;
      s10_tx2_q <= s9_tx2_q;
      s10_ty1_q <= s9_ty1_q;
      s10_ty2_q <= s9_ty2_q;
    end
    if (adv[11]) begin
      s11_ox_q <= s11_ox_d;
      s11_oy_q <= s11_oy_d;
    end
    if (adv[12]) begin
      s12_ix_q  <= s12_ix_d;
      s12_iy_q  <= s12_iy_d;
      s12_inb_q <= s12_inb_d;
    end
  end

  // outputs come straight from the last stage
  assign out_valid_o = vld_q[NSt-1];
  assign ideal_x_o   = s12_ix_q;
  assign ideal_y_o   = s12_iy_q;
  assign in_bounds_o = s12_inb_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an empty output stage never blocks the input
  `BLC_ASSERT_IMPL(a_no_stall_when_out_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o)
  // input only stalls when every stage is full and the output is held
  `BLC_ASSERT_IMPL(a_stall_only_when_full, clk_i, rst_ni, in_stall_o, (&vld_q) && out_stall_i)
  // an accepted request occupies the first stage next cycle
  `BLC_ASSERT_NEXT(a_accept_fills_stage0, clk_i, rst_ni, in_valid_i && !in_stall_o, vld_q[0])
  // in-bounds results are never negative
  `BLC_ASSERT_IMPL(a_inb_nonneg, clk_i, rst_ni, out_valid_o && in_bounds_o, !ideal_x_o[13] && !ideal_y_o[13])

endmodule

// ===== verif/brown_lens_distortion_correction_tb.sv =====
`timescale 1ns / 100ps

module brown_lens_distortion_correction_tb;

  localparam int unsigned ImageWidth  = 640;
  localparam int unsigned ImageHeight = 480;
  localparam int unsigned NormShift   = 10;
  localparam int unsigned HoldCycles  = 150;
  localparam logic [blc_pkg::CfgIdxW-1:0] RegUnused = 3'd7;
  localparam longint Q16Max = 64'sd2147483647;
  localparam longint RadMax = 64'sd1099511627776;

  typedef struct packed {
    logic signed [13:0] ideal_x;
    logic signed [13:0] ideal_y;
    logic               in_bounds;
  } corrected_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [blc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [blc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [11:0] pixel_x_i = '0;
  logic [11:0] pixel_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [13:0] ideal_x_o;
  logic signed [13:0] ideal_y_o;
  logic in_bounds_o;

  // shadow copy of the lens registers
  logic [15:0]        lens_cx = blc_pkg::CenterXRst;
  logic [15:0]        lens_cy = blc_pkg::CenterYRst;
  logic signed [31:0] lens_k1 = blc_pkg::K1Rst;
  logic signed [31:0] lens_k2 = blc_pkg::K2Rst;
  logic signed [31:0] lens_k3 = blc_pkg::K3Rst;
  logic signed [31:0] lens_p1 = blc_pkg::P1Rst;
  logic signed [31:0] lens_p2 = blc_pkg::P2Rst;

  corrected_t pending_pixels[$];
  corrected_t oldest_pixel;
  int mismatch_count = 0;

  // sender burst control
  int  burst_left = 0;
  bit  sender_gaps = 1'b1;

  // receiver stall pattern
  bit  hold_request = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  stall_on = 1'b0;

  brown_lens_distortion_correction #(
    .IMAGE_WIDTH (ImageWidth),
    .IMAGE_HEIGHT(ImageHeight),
    .NORM_SHIFT  (NormShift)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pixel_x_i  (pixel_x_i),
    .pixel_y_i  (pixel_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .ideal_x_o  (ideal_x_o),
    .ideal_y_o  (ideal_y_o),
    .in_bounds_o(in_bounds_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // offset in Q16 normalized units back to a saturated pixel coordinate
  function automatic longint offset_to_pixel(longint center, longint corr);
    longint t;
    t = center * 4096 + corr * (longint'(1) <<< NormShift);
    return clamp(t / 65536, -8192, 8191);
  endfunction

  // Brown-Conrady correction with the current lens registers
  function automatic corrected_t correct_pixel(logic [11:0] px, logic [11:0] py);
    longint cx, cy, x, y, x2, y2, r2, r4, r6, radial, xy, ox, oy, ix, iy;
    corrected_t res;
    cx = longint'(lens_cx);
    cy = longint'(lens_cy);
    x  = (longint'(px) * 16 - cx) * (longint'(1) <<< (12 - NormShift));
    y  = (longint'(py) * 16 - cy) * (longint'(1) <<< (12 - NormShift));
    x2 = (x * x) >>> 16;
    y2 = (y * y) >>> 16;
    r2 = (x * x + y * y) >>> 16;
    r4 = clamp((r2 * r2) >>> 16, 0, Q16Max);
    r6 = clamp((r4 * r2) >>> 16, 0, Q16Max);
    radial = (longint'(1) <<< 29) + ((longint'(lens_k1) * r2) >>> 16)
           + ((longint'(lens_k2) * r4) >>> 16) + ((longint'(lens_k3) * r6) >>> 16);
    radial = clamp(radial, -RadMax, RadMax);
    xy = (x * y) >>> 16;
    ox = ((x * radial) >>> 29) + ((longint'(lens_p1) * (r2 + 2 * x2)) >>> 29)
       + ((2 * longint'(lens_p2) * xy) >>> 29);
    oy = ((y * radial) >>> 29) + ((longint'(lens_p2) * (r2 + 2 * y2)) >>> 29)
       + ((2 * longint'(lens_p1) * xy) >>> 29);
    ix = offset_to_pixel(cx, ox);
    iy = offset_to_pixel(cy, oy);
    res.ideal_x   = ix[13:0];
    res.ideal_y   = iy[13:0];
    res.in_bounds = (ix >= 0 && ix < ImageWidth && iy >= 0 && iy < ImageHeight);
    return res;
  endfunction

  // result checking and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result: ideal_x %0d ideal_y %0d", ideal_x_o, ideal_y_o);
        mismatch_count++;
      end else begin
        oldest_pixel = pending_pixels.pop_front();
        if (ideal_x_o !== oldest_pixel.ideal_x) begin
          $error("ideal_x: expected %0d, actual %0d", oldest_pixel.ideal_x, ideal_x_o);
          mismatch_count++;
        end
        if (ideal_y_o !== oldest_pixel.ideal_y) begin
          $error("ideal_y: expected %0d, actual %0d", oldest_pixel.ideal_y, ideal_y_o);
          mismatch_count++;
        end
        if (in_bounds_o !== oldest_pixel.in_bounds) begin
          $error("in_bounds: expected %0b, actual %0b", oldest_pixel.in_bounds, in_bounds_o);
          mismatch_count++;
        end
      end
    end
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      // alternate stalled and free runs; free runs are sometimes long
      if (stall_left == 0) begin
        stall_on = !stall_on;
        if (stall_on) stall_left = $urandom_range(1, 6);
        else if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(40, 80);
        else stall_left = $urandom_range(1, 15);
      end
      stall_left--;
      out_stall_i <= stall_on;
    end
  end

  // one pixel request; gaps fall between bursts
  task automatic send_pixel(input logic [11:0] px, input logic [11:0] py);
    int gap;
    if (burst_left == 0) begin
      gap = (sender_gaps && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    pixel_x_i  <= px;
    pixel_y_i  <= py;
    do @(posedge clk_i); while (in_stall_o);
    pending_pixels.insert(pending_pixels.size(), correct_pixel(px, py));
    burst_left--;
  endtask

  // stop requesting and wait until every result is back
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller releases it
  task automatic write_reg(input logic [blc_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      blc_pkg::REG_CENTER_X: lens_cx = data[15:0];
      blc_pkg::REG_CENTER_Y: lens_cy = data[15:0];
      blc_pkg::REG_K1:       lens_k1 = data;
      blc_pkg::REG_K2:       lens_k2 = data;
      blc_pkg::REG_K3:       lens_k3 = data;
      blc_pkg::REG_P1:       lens_p1 = data;
      blc_pkg::REG_P2:       lens_p2 = data;
      default: ;
    endcase
  endtask

  task automatic set_lens(input logic [15:0] cx, input logic [15:0] cy,
                          input logic [31:0] k1, input logic [31:0] k2,
                          input logic [31:0] k3, input logic [31:0] p1,
                          input logic [31:0] p2);
    write_reg(blc_pkg::REG_CENTER_X, {16'd0, cx});
    write_reg(blc_pkg::REG_CENTER_Y, {16'd0, cy});
    write_reg(blc_pkg::REG_K1, k1);
    write_reg(blc_pkg::REG_K2, k2);
    write_reg(blc_pkg::REG_K3, k3);
    write_reg(blc_pkg::REG_P1, p1);
    write_reg(blc_pkg::REG_P2, p2);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // corners, image edges and center with the power-on lens
  task automatic test_reset_defaults();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd313, 12'd235);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd640, 12'd480);
    send_pixel(12'd1, 12'd1);
    wait_drain();
  endtask

  // saturating coefficients, far corners, identity lens, ignored index
  task automatic test_coefficient_extremes();
    set_lens(16'd0, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd0);
    wait_drain();
    set_lens(16'hFFFF, 16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    wait_drain();
    set_lens(16'd0, 16'd0, '0, '0, '0, '0, '0);
    // a write past the last register must leave the lens untouched
    write_reg(RegUnused, 32'hFFFF_FFFF);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd640, 12'd479);
    send_pixel(12'd639, 12'd480);
    send_pixel(12'd0, 12'd0);
    wait_drain();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall input
  task automatic test_pipeline_backpressure();
    set_lens(blc_pkg::CenterXRst, blc_pkg::CenterYRst, blc_pkg::K1Rst, blc_pkg::K2Rst,
             blc_pkg::K3Rst, blc_pkg::P1Rst, blc_pkg::P2Rst);
    sender_gaps = 1'b0;
    hold_request = 1'b1;
    repeat (60) send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
    sender_gaps = 1'b1;
    wait_drain();
  endtask

  // random lenses, mostly realistic, some full range
  task automatic test_random_lenses();
    logic [31:0] coef[5];
    logic [15:0] cx, cy;
    int lens_kind;
    for (int phase = 0; phase < 5; phase++) begin
      lens_kind = phase % 3;
      foreach (coef[i]) begin
        case (lens_kind)
          0: coef[i] = int'($urandom_range(0, 8000)) - 4000;
          1: coef[i] = int'($urandom_range(0, 2_000_000)) - 1_000_000;
          default: coef[i] = $urandom();
        endcase
      end
      if (lens_kind == 2) begin
        cx = 16'($urandom());
        cy = 16'($urandom());
      end else begin
        cx = 16'($urandom_range(4000, 6200));
        cy = 16'($urandom_range(3000, 4600));
      end
      set_lens(cx, cy, coef[0], coef[1], coef[2], coef[3], coef[4]);
      sender_gaps = (phase != 3);
      repeat (100) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(12'($urandom_range(0, ImageWidth - 1)),
                     12'($urandom_range(0, ImageHeight - 1)));
        else
          send_pixel(12'($urandom()), 12'($urandom()));
      end
      wait_drain();
    end
    sender_gaps = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_coefficient_extremes();
    test_pipeline_backpressure();
    test_random_lenses();
    wait_drain();
    repeat (blc_pkg::NumStages + 4) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/blc_pkg.sv
rtl/core/brown_lens_distortion_correction.sv
verif/brown_lens_distortion_correction_tb.sv
